/* hdl/shash_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// shared constants, types and state codes for the shift-add string hash
// no dependencies

package shash_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned HASH_W     = 32;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned SHIFT_WRAP = SUM_W - CHAR_W;
  localparam int unsigned TSZ_RESET  = 1024;
  localparam int unsigned DIV_CNT_W  = $clog2(SUM_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

/* hdl/shash_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// bit-serial restoring remainder unit, one dividend bit per cycle
// depends on shash_pkg

module shash_divider
  import shash_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [SUM_W-1:0]  dividend_i,
  input  wire logic [HASH_W-1:0] divisor_i,
  output div_stat_t              stat_o,
  output logic      [HASH_W-1:0] rem_o
);

  localparam int unsigned TRIAL_W = HASH_W + 1;

  logic [SUM_W-1:0]     dvd_q, dvd_d;
  logic [HASH_W-1:0]    dsr_q, dsr_d;
  logic [HASH_W-1:0]    rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  logic [TRIAL_W-1:0]   trial;
  logic [TRIAL_W-1:0]   diff;
  logic                 fits;

  assign trial = {rem_q, dvd_q[SUM_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[SUM_W-2:0], 1'b0};
      rem_d = fits ? diff[HASH_W-1:0] : trial[HASH_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

`default_nettype wire

/* hdl/shift_add_string_hash.sv */
`timescale 1ns / 1ps
`default_nettype none
// top level of the shift-add string hash: control, running state, output register
// depends on shash_pkg and shash_divider

// One character is taken per beat and added, shifted left by its position
// modulo 56, to a 32-bit running hash. A character whose sum stays at or
// below table_size (or with table_size zero) is added directly. A sum above
// table_size is reduced by the bit-serial remainder unit, which retires one
// dividend bit per cycle over 64 steps; no new character is taken meanwhile.
// A character marked last then loads the result register in the push state;
// the result waits there while the next key is already being taken in.
// table_size is written through cfg_we_i / cfg_wdata_i and resets to 1024.

module shift_add_string_hash
  import shash_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [HASH_W-1:0] cfg_wdata_i,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [CHAR_W-1:0] s_axis_tdata,   // char_byte[7:0]
  input  wire logic              s_axis_tlast,   // last_char
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [HASH_W-1:0] m_axis_tdata    // hash_value[31:0]
);

  state_e            state_q, state_d;
  logic [HASH_W-1:0] tsz_q, tsz_d;
  logic [HASH_W-1:0] hash_q, hash_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              last_q, last_d;
  logic              out_valid_q, out_valid_d;
  logic [HASH_W-1:0] out_data_q, out_data_d;

  logic [POS_W-1:0]  pos_eff;
  logic [POS_W-1:0]  pos_inc;
  logic [POS_W-1:0]  pos_nxt;
  logic [SUM_W-1:0]  sum;
  logic              need_div;
  logic              in_acc;
  logic              out_free;
  logic              div_start;
  logic              push;
  div_stat_t         div_stat;
  logic [HASH_W-1:0] div_rem;

  assign pos_eff  = (pos_q >= POS_W'(SHIFT_WRAP)) ? '0 : pos_q;
  assign pos_inc  = pos_eff + 1'b1;
  assign pos_nxt  = (pos_inc >= POS_W'(SHIFT_WRAP)) ? '0 : pos_inc;
  assign sum      = {{(SUM_W - HASH_W){1'b0}}, hash_q}
                  + (SUM_W'(s_axis_tdata) << pos_eff);
  assign need_div = (tsz_q != '0) && (sum > {{(SUM_W - HASH_W){1'b0}}, tsz_q});
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  shash_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum),
    .divisor_i  (tsz_q),
    .stat_o     (div_stat),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (need_div) begin
            state_d = ST_DIV;
          end else if (s_axis_tlast) begin
            state_d = ST_PUSH;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = last_q ? ST_PUSH : ST_IDLE;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    div_start     = (state_q == ST_IDLE) && in_acc && need_div;
    push          = (state_q == ST_PUSH) && out_free;
  end

  always_comb begin
    tsz_d  = cfg_we_i ? cfg_wdata_i : tsz_q;
    hash_d = hash_q;
    pos_d  = pos_q;
    last_d = last_q;
    if (in_acc) begin
      pos_d  = pos_nxt;
      last_d = s_axis_tlast;
      if (!need_div) begin
        hash_d = sum[HASH_W-1:0];
      end
    end
    if ((state_q == ST_DIV) && div_stat.done) begin
      hash_d = div_rem;
    end
    if (push) begin
      hash_d = '0;
      pos_d  = '0;
    end
    out_valid_d = push ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
    out_data_d  = push ? hash_q : out_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tsz_q       <= HASH_W'(TSZ_RESET);
      hash_q      <= '0;
      pos_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tsz_q       <= tsz_d;
      hash_q      <= hash_d;
      pos_q       <= pos_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
  // no beat is taken while the remainder unit is running
  a_ready_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_stat.busy)
    else $error("input ready while divider busy");

  // the divider finishes only while the control waits for it
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV))
    else $error("divider done outside of divide state");

  // a new result appears only out of the push state
  a_push_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_PUSH))
    else $error("result raised without push");
`endif

endmodule

`default_nettype wire
